// ----- hdl/assert_macros.svh -----
// concurrent assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hdl/bba_pkg.sv -----
package bba_pkg;

	localparam int NUM_BLOCKS_DEF = 1024;

	// bitmap word geometry
	localparam int WORD_W = 64;
	localparam int WORD_LG = 6;

	// field widths
	localparam int IDX_W = 10;
	localparam int CNT_W = 11;
	localparam int BASE_W = CNT_W + 1;
	localparam int REQ_W = 3;
	localparam int STAT_W = 2;
	localparam int IN_TDATA_W = 16;
	localparam int OUT_TDATA_W = 24;

	// register port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_TOTAL = 1'b0;
	localparam logic REG_RSVD = 1'b1;
	localparam logic [CNT_W-1:0] TOTAL_RST = 11'd1024;
	localparam logic [CNT_W-1:0] RSVD_RST = 11'd0;

	// request kinds
	localparam logic [REQ_W-1:0] REQ_INIT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_ALLOC = 3'd1;
	localparam logic [REQ_W-1:0] REQ_FREE = 3'd2;
	localparam logic [REQ_W-1:0] REQ_READ = 3'd3;
	localparam logic [REQ_W-1:0] REQ_WRITE = 3'd4;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

	// bitmap memory controls
	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} mem_ctl_t;

	// word whose bits are set where base + bit < cnt
	function automatic logic [WORD_W-1:0] init_word(input logic [BASE_W-1:0] base,
			input logic [BASE_W-1:0] cnt);
		logic [BASE_W:0] lim;
		logic [WORD_LG-1:0] n;
		lim = (BASE_W+1)'(base) + (BASE_W+1)'(WORD_W);
		n = WORD_LG'(cnt - base);
		if ((BASE_W+1)'(cnt) >= lim) begin
			return '1;
		end else if (cnt <= base) begin
			return '0;
		end else begin
			return ~({WORD_W{1'b1}} << n);
		end
	endfunction

endpackage

// ----- hdl/bba_bitmap_mem.sv -----
module bba_bitmap_mem #(
	parameter int NUM_WORDS = 16,
	parameter int WA_W = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bba_pkg::mem_ctl_t         ctl,
	input  logic [WA_W-1:0]           rd_addr,
	input  logic [WA_W-1:0]           wr_addr,
	input  logic [bba_pkg::WORD_W-1:0] wr_data,
	input  logic [bba_pkg::CNT_W-1:0]  clr_res,
	output logic [bba_pkg::WORD_W-1:0] rd_data
);
	import bba_pkg::*;

	logic [WORD_W-1:0] bitmap_mem [NUM_WORDS];
	logic [NUM_WORDS-1:0] vld_q;
	logic [CNT_W-1:0] res_q;
	logic [WORD_W-1:0] rdata_s1;
	logic [WA_W-1:0] raddr_s1;
	logic vld_s1;

	// word storage, registered read
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			bitmap_mem[wr_addr] <= wr_data;
		end
		if (ctl.rd) begin
			rdata_s1 <= bitmap_mem[rd_addr];
			raddr_s1 <= rd_addr;
		end
	end

	// per-word written marks and the reserved count of the last init
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			res_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (ctl.clr) begin
				vld_q <= '0;
				res_q <= clr_res;
			end else if (ctl.wr) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd) begin
				vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	// unwritten words read as the init pattern
	assign rd_data = vld_s1 ? rdata_s1 :
		init_word(BASE_W'({raddr_s1, {WORD_LG{1'b0}}}), BASE_W'(res_q));

endmodule

// ----- hdl/bba_ffz.sv -----
module bba_ffz #(
	parameter int WA_W = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       flush,
	input  logic                       in_vld,
	input  logic [bba_pkg::WORD_W-1:0]  in_free,
	input  logic [bba_pkg::WORD_W-1:0]  in_word,
	input  logic [WA_W-1:0]            in_addr,
	output logic                       out_vld,
	output logic                       out_hit,
	output logic [bba_pkg::WORD_LG-1:0] out_pos,
	output logic [bba_pkg::WORD_W-1:0]  out_word,
	output logic [WA_W-1:0]            out_addr
);
	import bba_pkg::*;

	localparam int NBYTE = WORD_W / 8;
	localparam int BYTE_LG = WORD_LG - 3;

	logic [NBYTE-1:0] byte_any;
	logic [2:0] byte_pos [NBYTE];
	logic [NBYTE-1:0] byte_any_s1;
	logic [2:0] byte_pos_s1 [NBYTE];
	logic [WORD_W-1:0] word_s1;
	logic [WA_W-1:0] addr_s1;
	logic vld_s1;
	logic [BYTE_LG-1:0] bsel;
	logic vld_s2;
	logic hit_s2;
	logic [WORD_LG-1:0] pos_s2;
	logic [WORD_W-1:0] word_s2;
	logic [WA_W-1:0] addr_s2;

	// lowest free bit inside each byte
	always_comb begin
		for (int g = 0; g < NBYTE; g++) begin
			byte_any[g] = |in_free[g*8 +: 8];
			byte_pos[g] = 3'd0;
			for (int j = 7; j >= 0; j--) begin
				if (in_free[g*8 + j]) begin
					byte_pos[g] = 3'(j);
				end
			end
		end
	end

	// lowest byte holding a free bit
	always_comb begin
		bsel = '0;
		for (int g = NBYTE - 1; g >= 0; g--) begin
			if (byte_any_s1[g]) begin
				bsel = BYTE_LG'(g);
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (flush) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	// stage data
	always_ff @(posedge clk) begin
		byte_any_s1 <= byte_any;
		byte_pos_s1 <= byte_pos;
		word_s1 <= in_word;
		addr_s1 <= in_addr;
		hit_s2 <= |byte_any_s1;
		pos_s2 <= {bsel, byte_pos_s1[bsel]};
		word_s2 <= word_s1;
		addr_s2 <= addr_s1;
	end

	assign out_vld = vld_s2;
	assign out_hit = hit_s2;
	assign out_pos = pos_s2;
	assign out_word = word_s2;
	assign out_addr = addr_s2;

endmodule

// ----- hdl/bitmap_block_allocator_core.sv -----
// channel     dir   handshake         payload
// s_*         in    tvalid / tready   tuser req_type, tdata block_index, bit_value
// m_*         out   tvalid / tready   tdata result_block, bit_read, status, free_blocks
// apb         in    psel / penable    0x0 total_blocks, 0x4 reserved_blocks
//
// init, unknown, out-of-range and refused allocate requests go from idle straight to
//   hold; read, free and write first pass through the read-modify-write state
// allocate reads one 64-bit bitmap word per cycle through a two-stage search:
//   a hit writes back the word with its bit set; no hit up to the last word is full
// reset needs no clearing pass: per-word written marks make unwritten words read
//   as the pattern of the last init (all free after reset)
// a result waits in the output register; one more request is taken and its
//   result held until the output register empties
`include "assert_macros.svh"

module bitmap_block_allocator_core #(
	parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [9:0] block_index, [10] bit_value, [15:11] zero
	input  logic [bba_pkg::IN_TDATA_W-1:0]  s_tdata,
	// [2:0] req_type
	input  logic [bba_pkg::REQ_W-1:0]       s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [9:0] result_block, [10] bit_read, [12:11] status, [23:13] free_blocks
	output logic [bba_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bba_pkg::PADDR_W-1:0]     paddr,
	input  logic [bba_pkg::PDATA_W-1:0]     pwdata,
	output logic [bba_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready
);
	import bba_pkg::*;

	localparam int CNT_SPAN = 1 << CNT_W;
	localparam int MEM_BLOCKS = (NUM_BLOCKS < CNT_SPAN) ? NUM_BLOCKS : CNT_SPAN;
	localparam int LIM_CAP = (NUM_BLOCKS < CNT_SPAN - 1) ? NUM_BLOCKS : CNT_SPAN - 1;
	localparam int NUM_WORDS = (MEM_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int WA_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int WP_W = $clog2(NUM_WORDS + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_RMW  = 4'b0100,
		S_HOLD = 4'b1000
	} state_t;

	state_t st_q;
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] rsvd_q;
	logic [CNT_W-1:0] free_q;
	logic [REQ_W-1:0] req_q;
	logic [IDX_W-1:0] idx_q;
	logic val_q;
	logic [WP_W-1:0] rd_ptr_q;
	logic [WP_W-1:0] nwords_q;
	logic [WA_W-1:0] last_q;
	logic [IDX_W-1:0] pend_blk_q;
	logic pend_bit_q;
	logic [STAT_W-1:0] pend_stat_q;
	logic out_vld_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic rd_vld_s1;
	logic [WA_W-1:0] scan_addr_s1;

	logic [CNT_W-1:0] limit;
	logic [CNT_W-1:0] res_eff;
	logic [BASE_W-1:0] nwords_full;
	logic [IDX_W-1:0] in_idx;
	logic in_val;
	logic in_range;
	logic accept;
	logic cfg_wr;
	logic reg_sel;
	mem_ctl_t mctl;
	logic [WA_W-1:0] rd_addr;
	logic [WA_W-1:0] wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic [WORD_W-1:0] rd_data;
	logic [WORD_W-1:0] bit_mask;
	logic [WORD_W-1:0] scan_free;
	logic ffz_vld;
	logic ffz_hit;
	logic [WORD_LG-1:0] ffz_pos;
	logic [WORD_W-1:0] ffz_word;
	logic [WA_W-1:0] ffz_addr;

	// register port
	assign pready = 1'b1;
	assign reg_sel = paddr[PADDR_W-1];
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = (reg_sel == REG_RSVD) ? PDATA_W'(rsvd_q) : PDATA_W'(total_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_RST;
			rsvd_q <= RSVD_RST;
		end else if (cfg_wr) begin
			if (reg_sel == REG_RSVD) begin
				rsvd_q <= pwdata[CNT_W-1:0];
			end else begin
				total_q <= pwdata[CNT_W-1:0];
			end
		end
	end

	// request fields and limits
	assign in_idx = s_tdata[IDX_W-1:0];
	assign in_val = s_tdata[IDX_W];
	assign limit = (total_q < CNT_W'(LIM_CAP)) ? total_q : CNT_W'(LIM_CAP);
	assign res_eff = (rsvd_q > limit) ? limit : rsvd_q;
	assign in_range = {1'b0, in_idx} < limit;
	assign nwords_full = (BASE_W'(limit) + BASE_W'(WORD_W - 1)) >> WORD_LG;
	assign s_tready = (st_q == S_IDLE);
	assign accept = s_tvalid & s_tready;
	assign bit_mask = WORD_W'(1) << idx_q[WORD_LG-1:0];

	// memory port control
	always_comb begin
		mctl = '0;
		rd_addr = rd_ptr_q[WA_W-1:0];
		wr_addr = WA_W'(idx_q >> WORD_LG);
		wr_data = rd_data;
		case (st_q)
			S_IDLE: begin
				if (accept) begin
					case (s_tuser)
						REQ_INIT: mctl.clr = 1'b1;
						REQ_FREE, REQ_READ, REQ_WRITE: begin
							mctl.rd = in_range;
							rd_addr = WA_W'(in_idx >> WORD_LG);
						end
						default: mctl = '0;
					endcase
				end
			end
			S_SCAN: begin
				mctl.rd = (rd_ptr_q < nwords_q);
				if (ffz_vld && ffz_hit) begin
					mctl.wr = 1'b1;
					wr_addr = ffz_addr;
					wr_data = ffz_word | (WORD_W'(1) << ffz_pos);
				end
			end
			S_RMW: begin
				case (req_q)
					REQ_FREE: begin
						mctl.wr = 1'b1;
						wr_data = rd_data & ~bit_mask;
					end
					REQ_WRITE: begin
						mctl.wr = 1'b1;
						wr_data = val_q ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
					end
					default: mctl.wr = 1'b0;
				endcase
			end
			default: mctl = '0;
		endcase
	end

	bba_bitmap_mem #(
		.NUM_WORDS(NUM_WORDS),
		.WA_W(WA_W)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(mctl),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.clr_res(res_eff),
		.rd_data(rd_data)
	);

	// free bits of a scanned word, blocks at or above the limit count as used
	assign scan_free = ~rd_data &
		init_word(BASE_W'({scan_addr_s1, {WORD_LG{1'b0}}}), BASE_W'(limit));

	bba_ffz #(
		.WA_W(WA_W)
	) u_ffz (
		.clk(clk),
		.arst_n(arst_n),
		.flush(st_q != S_SCAN),
		.in_vld(rd_vld_s1 && (st_q == S_SCAN)),
		.in_free(scan_free),
		.in_word(rd_data),
		.in_addr(scan_addr_s1),
		.out_vld(ffz_vld),
		.out_hit(ffz_hit),
		.out_pos(ffz_pos),
		.out_word(ffz_word),
		.out_addr(ffz_addr)
	);

	// read tracking for the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			scan_addr_s1 <= '0;
		end else begin
			rd_vld_s1 <= mctl.rd;
			scan_addr_s1 <= rd_addr;
		end
	end

	// request sequencer, free count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			free_q <= '0;
			req_q <= REQ_INIT;
			idx_q <= '0;
			val_q <= 1'b0;
			rd_ptr_q <= '0;
			nwords_q <= '0;
			last_q <= '0;
			pend_blk_q <= '0;
			pend_bit_q <= 1'b0;
			pend_stat_q <= STAT_OK;
			out_vld_q <= 1'b0;
			out_data_q <= '0;
		end else begin
			if (out_vld_q && m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (accept) begin
						req_q <= s_tuser;
						idx_q <= in_idx;
						val_q <= in_val;
						pend_blk_q <= in_idx;
						pend_bit_q <= 1'b0;
						pend_stat_q <= STAT_OK;
						st_q <= S_HOLD;
						case (s_tuser)
							REQ_INIT: begin
								free_q <= limit - res_eff;
								pend_blk_q <= '0;
							end
							REQ_ALLOC: begin
								pend_blk_q <= '0;
								if (free_q == '0 || limit == '0) begin
									pend_stat_q <= STAT_FULL;
								end else begin
									rd_ptr_q <= '0;
									nwords_q <= WP_W'(nwords_full);
									last_q <= WA_W'(nwords_full - 1'b1);
									st_q <= S_SCAN;
								end
							end
							REQ_FREE, REQ_READ, REQ_WRITE: begin
								if (!in_range) begin
									pend_stat_q <= STAT_RANGE;
								end else begin
									st_q <= S_RMW;
								end
							end
							default: pend_stat_q <= STAT_OK;
						endcase
					end
				end
				S_SCAN: begin
					if (mctl.rd) begin
						rd_ptr_q <= rd_ptr_q + 1'b1;
					end
					if (ffz_vld) begin
						if (ffz_hit) begin
							free_q <= free_q - 1'b1;
							pend_blk_q <= IDX_W'({ffz_addr, ffz_pos});
							st_q <= S_HOLD;
						end else if (ffz_addr == last_q) begin
							pend_stat_q <= STAT_FULL;
							st_q <= S_HOLD;
						end
					end
				end
				S_RMW: begin
					case (req_q)
						REQ_FREE: begin
							if (free_q < limit) begin
								free_q <= free_q + 1'b1;
							end
						end
						REQ_READ: pend_bit_q <= rd_data[idx_q[WORD_LG-1:0]];
						default: pend_bit_q <= 1'b0;
					endcase
					st_q <= S_HOLD;
				end
				S_HOLD: begin
					if (!out_vld_q || m_tready) begin
						out_vld_q <= 1'b1;
						out_data_q <= {free_q, pend_stat_q, pend_bit_q, pend_blk_q};
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = out_data_q;

	// checks
	`ASSERT_IMPL(a_scan_nonempty, clk, arst_n, st_q == S_SCAN, free_q != '0, "scan with zero free count")
	`ASSERT_NEXT(a_alloc_dec, clk, arst_n, (st_q == S_SCAN) && ffz_vld && ffz_hit, free_q == $past(free_q) - 1'b1, "allocate did not decrement free count")
	`ASSERT_IMPL(a_wr_state, clk, arst_n, mctl.wr, (st_q == S_SCAN) || (st_q == S_RMW), "bitmap write outside scan or update")

endmodule
